// ===== hw/rtl/esd_pkg.sv =====
// Escape sequence decoder package: shared types, constants and helper functions.
// No dependencies; every other RTL file of the decoder refers to it by scoped names.
package esd_pkg;

    localparam int KEY_W           = 16;
    localparam int BYTE_W          = 8;
    localparam int CODE_WIDTH_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SLOTS           = 3;

    localparam logic [KEY_W-1:0] LIMIT_RESET = 16'd79;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_X_LO   = 8'h78;
    localparam logic [BYTE_W-1:0] CH_X_UP   = 8'h58;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_ESC,
        MODE_HEX,
        MODE_OCT
    } mode_t;

    // One accepted byte's worth of results, oldest in slot 0.
    typedef struct packed {
        logic [SLOTS-1:0][KEY_W-1:0] codes;
        logic [1:0]                  cnt;
        logic                        term;
    } bundle_t;

    typedef struct packed {
        logic             hit;
        logic [BYTE_W-1:0] code;
    } esc_hit_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] val;
    } hex_hit_t;

    function automatic esc_hit_t simple_escape(input logic [BYTE_W-1:0] b);
        esc_hit_t r;
        r.hit = 1'b1;
        unique case (b)
            8'h61:   r.code = 8'h07;
            8'h62:   r.code = 8'h08;
            8'h74:   r.code = 8'h09;
            8'h6E:   r.code = 8'h0A;
            8'h76:   r.code = 8'h0B;
            8'h66:   r.code = 8'h0C;
            8'h72:   r.code = 8'h0D;
            8'h65:   r.code = 8'h1B;
            8'h22:   r.code = 8'h22;
            8'h27:   r.code = 8'h27;
            8'h5C:   r.code = 8'h5C;
            default:
            begin
                r.hit  = 1'b0;
                r.code = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic hex_hit_t hex_digit(input logic [BYTE_W-1:0] b);
        hex_hit_t r;
        r.hit = 1'b1;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r.val = b[3:0];
        end
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
        begin
            r.val = b[3:0] + 4'd9;
        end
        else
        begin
            r.hit = 1'b0;
            r.val = 4'd0;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/escape_sequence_decoder.sv =====
// Escape sequence decoder top level: front end, bundle queue and back end.
// Depends on esd_pkg, esd_front, esd_queue and esd_back.
//
// Decodes a C-style escaped string, one byte per request on the push/full side, into
// 16-bit key codes on the pop/empty side. Plain bytes pass sign-extended; a backslash
// starts an escape (letter escapes, \x with one to four hex digits, one to six octal
// digits); a malformed escape gives a literal backslash and the byte is taken again as
// fresh. A zero byte flushes what is pending, ends the string with a zero code marked
// is_terminator, and restarts the per-string count. Once cfg_code_limit codes of a
// string have gone out, further codes are dropped, but the closing code never is.
// last_of_run marks the final result caused by one input byte; a byte may cause none.
// Rate: one byte per cycle as long as each byte yields at most one result and pop is
// high every cycle. A byte that yields two or three results holds the single result
// register until each has gone out; the QUEUE_DEPTH-entry bundle queue absorbs such
// bursts, and full rises only when it fills. The first result of a byte passes through
// the bundle queue and then the result register before it shows on the ports. cfg_ready
// is always high; write the limit only while no request is in flight.
module escape_sequence_decoder #(
    parameter int CODE_WIDTH  = esd_pkg::CODE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [esd_pkg::KEY_W-1:0]  cfg_code_limit,
    input  logic                       push,
    output logic                       full,
    input  logic [esd_pkg::BYTE_W-1:0] char_byte,
    input  logic                       pop,
    output logic                       empty,
    output logic [esd_pkg::KEY_W-1:0]  decoded_code,
    output logic                       is_terminator,
    output logic                       last_of_run
);

    // Bundle handoff between the parser and the result side.
    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    esd_pkg::bundle_t q_wr_bundle;
    esd_pkg::bundle_t q_head;

    // Parse each byte, apply the code limit, and hand at most one bundle per byte onward.
    esd_front #(
        .CODE_WIDTH (CODE_WIDTH)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_code_limit (cfg_code_limit),
        .push           (push),
        .full           (full),
        .char_byte      (char_byte),
        .q_push         (q_push),
        .q_bundle       (q_wr_bundle),
        .q_full         (q_full)
    );

    // Hold bundles so the parser keeps going while multi-result bytes drain.
    esd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_bundle),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_empty (q_empty)
    );

    // Advance through each bundle one result at a time into the output register.
    esd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .decoded_code  (decoded_code),
        .is_terminator (is_terminator),
        .last_of_run   (last_of_run)
    );

endmodule

// ===== hw/rtl/esd_front.sv =====
// Escape sequence decoder front end: parse state machine, code limit and counter.
// Depends on esd_pkg; emits at most one bundle, of up to three codes, per accepted byte.
module esd_front #(
    parameter int CODE_WIDTH = esd_pkg::CODE_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [esd_pkg::KEY_W-1:0]    cfg_code_limit,
    input  logic                         push,
    output logic                         full,
    input  logic [esd_pkg::BYTE_W-1:0]   char_byte,
    output logic                         q_push,
    output esd_pkg::bundle_t             q_bundle,
    input  logic                         q_full
);

    localparam int KW = esd_pkg::KEY_W;

    esd_pkg::mode_t           mode_reg, mode_next;
    logic [CODE_WIDTH-1:0]    acc_reg, acc_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [KW-1:0]            limit_reg;
    logic [KW-1:0]            emitted_reg, emitted_next;

    esd_pkg::esc_hit_t        sc;
    esd_pkg::hex_hit_t        hx;
    logic                     is_oct;
    logic [2:0]               cnt_inc;
    logic [CODE_WIDTH-1:0]    acc_hex;
    logic [CODE_WIDTH-1:0]    acc_oct;
    logic [KW-1:0]            pre0, pre1, fcode;
    logic [1:0]               npre;
    logic                     do_fresh;
    logic                     plain;
    logic                     term;
    logic [1:0]               nreq;
    logic [KW-1:0]            diff;
    logic [1:0]               avail;
    logic [1:0]               kept;
    logic [esd_pkg::SLOTS-1:0][KW-1:0] cand;
    logic                     accept;

    assign cfg_ready = 1'b1;
    assign full      = q_full;
    assign accept    = push && !q_full;

    assign sc      = esd_pkg::simple_escape(char_byte);
    assign hx      = esd_pkg::hex_digit(char_byte);
    assign is_oct  = (char_byte[7:3] == 5'b00110);
    assign cnt_inc = cnt_reg + 3'd1;
    assign acc_hex = (cnt_reg == 3'd0) ? CODE_WIDTH'(hx.val) : {acc_reg[CODE_WIDTH-5:0], hx.val};
    assign acc_oct = {acc_reg[CODE_WIDTH-4:0], char_byte[2:0]};

    always_comb
    begin
        mode_next = mode_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        pre0      = '0;
        pre1      = '0;
        npre      = 2'd0;
        do_fresh  = 1'b0;
        term      = 1'b0;
        plain     = 1'b0;
        fcode     = '0;
        unique case (mode_reg)
            esd_pkg::MODE_ESC:
            begin
                priority if (sc.hit)
                begin
                    pre0      = KW'(sc.code);
                    npre      = 2'd1;
                    mode_next = esd_pkg::MODE_IDLE;
                    acc_next  = '0;
                    cnt_next  = 3'd0;
                end
                else if (char_byte == esd_pkg::CH_X_LO || char_byte == esd_pkg::CH_X_UP)
                begin
                    mode_next = esd_pkg::MODE_HEX;
                    acc_next  = CODE_WIDTH'(char_byte);
                    cnt_next  = 3'd0;
                end
                else if (is_oct)
                begin
                    mode_next = esd_pkg::MODE_OCT;
                    acc_next  = CODE_WIDTH'(char_byte[2:0]);
                    cnt_next  = 3'd1;
                end
                else
                begin
                    pre0     = KW'(esd_pkg::CH_BSLASH);
                    npre     = 2'd1;
                    do_fresh = 1'b1;
                end
            end
            esd_pkg::MODE_HEX:
            begin
                if (hx.hit)
                begin
                    acc_next = acc_hex;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd4)
                    begin
                        pre0      = acc_hex[KW-1:0];
                        npre      = 2'd1;
                        mode_next = esd_pkg::MODE_IDLE;
                        acc_next  = '0;
                        cnt_next  = 3'd0;
                    end
                end
                else
                begin
                    // no digits yet: emit the backslash and the x letter as they stood
                    if (cnt_reg == 3'd0)
                    begin
                        pre0 = KW'(esd_pkg::CH_BSLASH);
                        pre1 = acc_reg[KW-1:0];
                        npre = 2'd2;
                    end
                    else
                    begin
                        pre0 = acc_reg[KW-1:0];
                        npre = 2'd1;
                    end
                    do_fresh = 1'b1;
                end
            end
            esd_pkg::MODE_OCT:
            begin
                if (is_oct)
                begin
                    acc_next = acc_oct;
                    cnt_next = cnt_inc;
                    if (cnt_inc >= 3'd6)
                    begin
                        pre0      = acc_oct[KW-1:0];
                        npre      = 2'd1;
                        mode_next = esd_pkg::MODE_IDLE;
                        acc_next  = '0;
                        cnt_next  = 3'd0;
                    end
                end
                else
                begin
                    pre0     = acc_reg[KW-1:0];
                    npre     = 2'd1;
                    do_fresh = 1'b1;
                end
            end
            esd_pkg::MODE_IDLE:
            begin
                do_fresh = 1'b1;
            end
            default:
            begin
                do_fresh = 1'b1;
            end
        endcase

        // handle the byte as the start of something new
        if (do_fresh)
        begin
            mode_next = esd_pkg::MODE_IDLE;
            acc_next  = '0;
            cnt_next  = 3'd0;
            if (char_byte == esd_pkg::CH_NUL)
            begin
                term = 1'b1;
            end
            else if (char_byte == esd_pkg::CH_BSLASH)
            begin
                mode_next = esd_pkg::MODE_ESC;
            end
            else
            begin
                plain = 1'b1;
                fcode = {{(KW-esd_pkg::BYTE_W){char_byte[7]}}, char_byte};
            end
        end
    end

    // Keep only as many codes as the limit still allows; the closing code always passes.
    assign nreq  = npre + {1'b0, plain};
    assign diff  = limit_reg - emitted_reg;
    assign avail = (emitted_reg >= limit_reg) ? 2'd0 : ((|diff[KW-1:2]) ? 2'd3 : diff[1:0]);
    assign kept  = (nreq < avail) ? nreq : avail;

    assign cand[0] = (npre >= 2'd1) ? pre0 : fcode;
    assign cand[1] = (npre >= 2'd2) ? pre1 : fcode;
    assign cand[2] = fcode;

    always_comb
    begin
        for (int i = 0; i < esd_pkg::SLOTS; i++)
        begin
            q_bundle.codes[i] = (2'(i) < kept) ? cand[i] : '0;
        end
        q_bundle.cnt  = kept + {1'b0, term};
        q_bundle.term = term;
    end

    assign q_push       = accept && (q_bundle.cnt != 2'd0);
    assign emitted_next = term ? '0 : (emitted_reg + KW'(kept));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= esd_pkg::MODE_IDLE;
            acc_reg     <= '0;
            cnt_reg     <= 3'd0;
            emitted_reg <= '0;
            limit_reg   <= esd_pkg::LIMIT_RESET;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                acc_reg     <= acc_next;
                cnt_reg     <= cnt_next;
                emitted_reg <= emitted_next;
            end
            if (cfg_valid)
            begin
                limit_reg <= cfg_code_limit;
            end
        end
    end

endmodule

// ===== hw/rtl/esd_queue.sv =====
// Escape sequence decoder bundle queue between front end and back end.
// Depends on esd_pkg for the bundle type; flop storage, head shown combinationally.
module esd_queue #(
    parameter int DEPTH = esd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  esd_pkg::bundle_t wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output esd_pkg::bundle_t rd_data,
    output logic             q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    esd_pkg::bundle_t  mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;
    logic              do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/esd_back.sv =====
// Escape sequence decoder back end: splits bundles into single results.
// Depends on esd_pkg; drives the registered result ports.
module esd_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  esd_pkg::bundle_t          q_head,
    output logic                      q_pop,
    input  logic                      pop,
    output logic                      empty,
    output logic [esd_pkg::KEY_W-1:0] decoded_code,
    output logic                      is_terminator,
    output logic                      last_of_run
);

    logic [1:0]                 idx_reg;
    logic                       out_valid_reg;
    logic [esd_pkg::KEY_W-1:0]  key_reg;
    logic                       term_reg;
    logic                       last_reg;
    logic                       load;
    logic                       is_last;

    assign empty         = !out_valid_reg;
    assign decoded_code  = key_reg;
    assign is_terminator = term_reg;
    assign last_of_run   = last_reg;

    assign load    = !q_empty && (!out_valid_reg || pop);
    assign is_last = (idx_reg == q_head.cnt - 2'd1);
    assign q_pop   = load && is_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_reg  <= q_head.codes[idx_reg];
            term_reg <= q_head.term && is_last;
            last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                idx_reg       <= is_last ? 2'd0 : idx_reg + 2'd1;
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/esd_checker.sv =====
// Escape sequence decoder port checker and its bind to the top level.
// Depends on esd_pkg for widths; watches the top-level ports only.
module esd_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cfg_ready,
    input logic                      pop,
    input logic                      empty,
    input logic [esd_pkg::KEY_W-1:0] decoded_code,
    input logic                      is_terminator,
    input logic                      last_of_run
);

    // The closing code is zero and always ends the run of its byte.
    a_term_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && is_terminator) |-> (decoded_code == '0 && last_of_run))
        else $error("terminator result is not a zero code ending its run");

    // A waiting result holds until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(decoded_code)
                              && $stable(is_terminator) && $stable(last_of_run)))
        else $error("waiting result changed before it was taken");

    // Nothing shows on the result side right out of reset.
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> empty)
        else $error("result shown directly after reset");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge clk)
        rst_n |-> cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind escape_sequence_decoder esd_checker u_esd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .pop           (pop),
    .empty         (empty),
    .decoded_code  (decoded_code),
    .is_terminator (is_terminator),
    .last_of_run   (last_of_run)
);

// ===== test/escape_sequence_decoder_checker.sv =====
`timescale 1ns / 1ps
// Checker for the escape sequence decoder: predicts key codes from accepted bytes
// and compares them, in order, with popped results. Depends on esd_pkg.
module escape_sequence_decoder_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [esd_pkg::KEY_W-1:0]  cfg_code_limit,
    input  logic                       push,
    input  logic                       full,
    input  logic [esd_pkg::BYTE_W-1:0] char_byte,
    input  logic                       pop,
    input  logic                       empty,
    input  logic [esd_pkg::KEY_W-1:0]  decoded_code,
    input  logic                       is_terminator,
    input  logic                       last_of_run,
    output int                         fail_count,
    output int                         pending
);

    import esd_pkg::*;

    typedef struct {
        logic [KEY_W-1:0] code;
        logic             term;
        logic             last;
    } key_result_t;

    logic [KEY_W-1:0] limit_reg;
    mode_t            mode;
    logic [KEY_W-1:0] accum;
    int unsigned      ndigits;
    int unsigned      emitted;

    key_result_t run_q[$];
    key_result_t key_q[$];

    // Append one code to this byte's run, or drop it once the string is over its limit.
    function automatic void emit_code(input logic [KEY_W-1:0] code, input logic term);
        if (!term)
        begin
            if (emitted >= limit_reg)
                return;
            emitted++;
        end
        run_q.push_back('{code, term, 1'b0});
    endfunction

    function automatic void go_idle();
        mode    = MODE_IDLE;
        accum   = '0;
        ndigits = 0;
    endfunction

    function automatic void take_fresh(input logic [BYTE_W-1:0] b);
        go_idle();
        if (b == CH_NUL)
        begin
            emit_code('0, 1'b1);
            emitted = 0;
        end
        else if (b == CH_BSLASH)
            mode = MODE_ESC;
        else
            emit_code({{(KEY_W-BYTE_W){b[BYTE_W-1]}}, b}, 1'b0);
    endfunction

    // Letter escapes: a b t n v f r e, double quote, quote, backslash.
    function automatic bit letter_code(input logic [BYTE_W-1:0] b,
                                       output logic [BYTE_W-1:0] code);
        bit hit;
        hit = 1'b1;
        case (b)
            8'h61:   code = 8'h07;
            8'h62:   code = 8'h08;
            8'h74:   code = 8'h09;
            8'h6E:   code = 8'h0A;
            8'h76:   code = 8'h0B;
            8'h66:   code = 8'h0C;
            8'h72:   code = 8'h0D;
            8'h65:   code = 8'h1B;
            8'h22:   code = 8'h22;
            8'h27:   code = 8'h27;
            8'h5C:   code = 8'h5C;
            default:
            begin
                code = 8'h00;
                hit  = 1'b0;
            end
        endcase
        return hit;
    endfunction

    function automatic int hex_value(input logic [BYTE_W-1:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return int'(b) - 'h30;
        if (b >= 8'h41 && b <= 8'h46)
            return int'(b) - 'h41 + 10;
        if (b >= 8'h61 && b <= 8'h66)
            return int'(b) - 'h61 + 10;
        return -1;
    endfunction

    function automatic bit is_octal(input logic [BYTE_W-1:0] b);
        return b >= 8'h30 && b <= 8'h37;
    endfunction

    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] lc;
        int                hv;
        run_q.delete();
        case (mode)
            MODE_ESC:
            begin
                if (letter_code(b, lc))
                begin
                    emit_code({{(KEY_W-BYTE_W){1'b0}}, lc}, 1'b0);
                    go_idle();
                end
                else if (b == CH_X_LO || b == CH_X_UP)
                begin
                    mode    = MODE_HEX;
                    accum   = {{(KEY_W-BYTE_W){1'b0}}, b};
                    ndigits = 0;
                end
                else if (is_octal(b))
                begin
                    mode    = MODE_OCT;
                    accum   = {{(KEY_W-3){1'b0}}, b[2:0]};
                    ndigits = 1;
                end
                else
                begin
                    emit_code({{(KEY_W-BYTE_W){1'b0}}, CH_BSLASH}, 1'b0);
                    take_fresh(b);
                end
            end
            MODE_HEX:
            begin
                hv = hex_value(b);
                if (hv >= 0)
                begin
                    if (ndigits == 0)
                        accum = KEY_W'(hv);
                    else
                        accum = {accum[KEY_W-5:0], 4'(hv)};
                    ndigits++;
                    if (ndigits >= 4)
                    begin
                        emit_code(accum, 1'b0);
                        go_idle();
                    end
                end
                else
                begin
                    // No digits yet: the pending x letter still sits in accum.
                    if (ndigits == 0)
                        emit_code({{(KEY_W-BYTE_W){1'b0}}, CH_BSLASH}, 1'b0);
                    emit_code(accum, 1'b0);
                    take_fresh(b);
                end
            end
            MODE_OCT:
            begin
                if (is_octal(b))
                begin
                    accum = (accum << 3) + {{(KEY_W-3){1'b0}}, b[2:0]};
                    ndigits++;
                    if (ndigits >= 6)
                    begin
                        emit_code(accum, 1'b0);
                        go_idle();
                    end
                end
                else
                begin
                    emit_code(accum, 1'b0);
                    take_fresh(b);
                end
            end
            default:
                take_fresh(b);
        endcase
        if (run_q.size() > 0)
            run_q[run_q.size()-1].last = 1'b1;
        foreach (run_q[i])
            key_q.push_back(run_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        key_result_t want;
        if (!rst_n)
        begin
            limit_reg  = LIMIT_RESET;
            emitted    = 0;
            go_idle();
            key_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                limit_reg = cfg_code_limit;
            if (push && !full)
                decode_byte(char_byte);
            if (pop && !empty)
            begin
                if (key_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result decoded_code=%h term=%b last=%b",
                                 $realtime, decoded_code, is_terminator, last_of_run);
                end
                else
                begin
                    want = key_q.pop_front();
                    if (want.code !== decoded_code || want.term !== is_terminator ||
                        want.last !== last_of_run)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %h/%b/%b got %h/%b/%b",
                                     $realtime, want.code, want.term, want.last,
                                     decoded_code, is_terminator, last_of_run);
                    end
                end
            end
            pending = key_q.size();
        end
    end

endmodule

// ===== test/escape_sequence_decoder_test.sv =====
`timescale 1ns / 1ps
// Top of the escape sequence decoder testbench: clock, reset, byte stimulus and verdict.
// Depends on esd_pkg, escape_sequence_decoder and escape_sequence_decoder_checker.
module escape_sequence_decoder_test;

    import esd_pkg::*;

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [KEY_W-1:0]  cfg_code_limit = '0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] char_byte = '0;
    logic              pop = 1'b0;
    logic              empty;
    logic [KEY_W-1:0]  decoded_code;
    logic              is_terminator;
    logic              last_of_run;

    int fail_count;
    int pending;

    // Idle odds in percent per cycle, and the cycles left in a forced receiver hold.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;

    logic [BYTE_W-1:0] text_q[$];

    localparam logic [BYTE_W-1:0] LETTERS[11] = '{8'h61, 8'h62, 8'h74, 8'h6E, 8'h76,
                                                  8'h66, 8'h72, 8'h65, 8'h22, 8'h27,
                                                  8'h5C};

    escape_sequence_decoder i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_code_limit (cfg_code_limit),
        .push           (push),
        .full           (full),
        .char_byte      (char_byte),
        .pop            (pop),
        .empty          (empty),
        .decoded_code   (decoded_code),
        .is_terminator  (is_terminator),
        .last_of_run    (last_of_run)
    );

    escape_sequence_decoder_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_code_limit (cfg_code_limit),
        .push           (push),
        .full           (full),
        .char_byte      (char_byte),
        .pop            (pop),
        .empty          (empty),
        .decoded_code   (decoded_code),
        .is_terminator  (is_terminator),
        .last_of_run    (last_of_run),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: pop at random, except while a forced hold is counting down.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            pop <= 1'b0;
            hold_left--;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic logic [BYTE_W-1:0] hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return BYTE_W'(8'h30 + v);
        return BYTE_W'(($urandom_range(1) ? 8'h61 : 8'h41) + v - 10);
    endfunction

    // Append one random piece of text: mostly well-formed escapes, some noise.
    task automatic add_token();
        int roll;
        int n;
        logic [BYTE_W-1:0] b;
        roll = $urandom_range(99);
        if (roll < 28)
        begin
            b = BYTE_W'($urandom_range(1, 255));
            text_q.push_back(b == CH_BSLASH ? 8'h41 : b);
        end
        else if (roll < 44)
        begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(LETTERS[$urandom_range(10)]);
        end
        else if (roll < 60)
        begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back($urandom_range(1) ? CH_X_LO : CH_X_UP);
            n = $urandom_range(4);
            repeat (n) text_q.push_back(hex_char());
        end
        else if (roll < 73)
        begin
            text_q.push_back(CH_BSLASH);
            n = $urandom_range(1, 6);
            repeat (n) text_q.push_back(BYTE_W'(8'h30 + $urandom_range(7)));
        end
        else if (roll < 80)
        begin
            text_q.push_back(CH_BSLASH);
            text_q.push_back(BYTE_W'($urandom_range(255)));
        end
        else if (roll < 90)
            text_q.push_back(CH_NUL);
        else
            text_q.push_back(BYTE_W'($urandom_range(255)));
    endtask

    // Offer every queued byte in turn; start a receiver hold at byte hold_at.
    task automatic send_text(input int hold_at);
        int idx;
        idx = 0;
        while (text_q.size() > 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                push <= 1'b0;
                @(negedge clk);
            end
            push      <= 1'b1;
            char_byte <= text_q.pop_front();
            do
                @(posedge clk);
            while (full);
            if (idx == hold_at)
                hold_left = 80;
            idx++;
            @(negedge clk);
        end
        push <= 1'b0;
    endtask

    // Wait until every expected code is out, plus a margin for bytes that gave none.
    task automatic wait_quiet();
        while (pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    // Write the per-string code limit; only called with no request in flight.
    task automatic write_limit(input logic [KEY_W-1:0] value);
        wait_quiet();
        cfg_valid      <= 1'b1;
        cfg_code_limit <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int nbytes, input int hold_at);
        while (text_q.size() < nbytes)
            add_token();
        send_text(hold_at);
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed text under the reset limit: plain and sign-extended bytes, a letter
        // escape, an unknown letter, \x with no digit, a full hex run, a full octal run,
        // a short octal run closed by a digit 8, and an octal escape cut by the zero byte.
        send_idle_pct = 17;
        recv_idle_pct = 87;
        text_q = '{8'h41, 8'hFF,
                   8'h5C, 8'h6E,
                   8'h5C, 8'h71,
                   8'h5C, 8'h78, 8'h47,
                   8'h5C, 8'h58, 8'h66, 8'h46, 8'h30, 8'h39,
                   8'h5C, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
                   8'h5C, 8'h37, 8'h38,
                   8'h5C, 8'h33, 8'h00};
        send_text(-1);

        // Tight limit: most strings overflow and drop codes.
        write_limit(16'd3);
        random_phase(60, -1);

        // Largest limit, with the idle odds swapped.
        write_limit(16'hFFFF);
        send_idle_pct = 87;
        recv_idle_pct = 17;
        random_phase(50, -1);

        // Limit of one at full rate.
        write_limit(16'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(40, -1);

        // Moderate limit; hold the receiver so the queue fills and full rises.
        write_limit(KEY_W'($urandom_range(8, 40)));
        random_phase(50, 10);

        // Drain: keep popping, then give stray results time to show.
        recv_idle_pct = 0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/esd_pkg.sv
hw/rtl/esd_front.sv
hw/rtl/esd_queue.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder.sv
hw/rtl/esd_checker.sv
test/escape_sequence_decoder_checker.sv
test/escape_sequence_decoder_test.sv
